// ===== design/rts_pkg.sv =====
package rts_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int HIT_IDX_W = 8;
    localparam int KEY_W = 32;
    localparam int REQ_W = 3;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W = 160;
    localparam int OUT_DATA_W = 136;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BIN_ID = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LIN_ID = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIN_PRICE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [31:0] rating;
        logic [31:0] sold;
        logic [31:0] price;
        logic [31:0] id;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIN,
        S_BIN_ISSUE,
        S_BIN_CHECK,
        S_OUT
    } state_t;

endpackage

// ===== design/rts_ram.sv =====
module rts_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/record_table_search.sv =====
// Record table with append, clear and search requests. Each input word is one
// request and returns exactly one result word; the next request is taken once
// the previous result sits in the output register. Clear and append go from
// idle straight to the output state. A linear search by id or price streams
// the table through the one read port of the record memory, one entry per
// cycle. Each probe of a binary search issues the address, then compares
// against the registered read data. The record memory holds no reset value
// and needs no clearing pass; only entries below the record count are ever
// read.
module record_table_search (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // search_key, new_id, new_price, new_sold, new_rating_bits
    input  logic [rts_pkg::IN_DATA_W-1:0]      s_tdata,
    // req_type
    input  logic [rts_pkg::REQ_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit_index, hit_id, hit_price, hit_sold, hit_rating_bits
    output logic [rts_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status
    output logic [rts_pkg::STATUS_W-1:0]       m_tuser
);
    import rts_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic lin_price_reg, lin_price_next;
    logic [CNT_W-1:0] lin_addr_reg, lin_addr_next;
    logic chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    rec_t res_rec_reg, res_rec_next;
    logic m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [IDX_W-1:0] m_idx_reg;
    rec_t m_rec_reg;

    logic s_accept;
    logic out_free;
    logic wr_en;
    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    rec_t rd_rec;
    rec_t new_rec;
    logic [REC_W-1:0] rd_data;
    logic lin_issue;
    logic lin_hit;
    logic [CNT_W-1:0] mid_calc;
    logic [31:0] lin_field;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign new_rec.id = s_tdata[63:32];
    assign new_rec.price = s_tdata[95:64];
    assign new_rec.sold = s_tdata[127:96];
    assign new_rec.rating = s_tdata[159:128];

    assign rd_rec = rec_t'(rd_data);
    assign lin_issue = (lin_addr_reg < count_reg);
    assign lin_field = lin_price_reg ? rd_rec.price : rd_rec.id;
    assign lin_hit = chk_valid_reg && (lin_field == key_reg);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg - CNT_W'(1)) >> 1);

    assign wr_en = s_accept && (s_tuser == REQ_APPEND) && (count_reg < CNT_W'(TABLE_DEPTH));
    assign rd_en = (state_reg == S_LIN) || (state_reg == S_BIN_ISSUE);
    assign rd_addr = (state_reg == S_LIN) ? lin_addr_reg[IDX_W-1:0] : mid_calc[IDX_W-1:0];

    rts_ram #(
        .WIDTH(REC_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk(aclk),
        .wr_en(wr_en),
        .wr_addr(count_reg[IDX_W-1:0]),
        .wr_data(new_rec),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (s_tuser) inside
                        REQ_BIN_ID: state_next = S_BIN_ISSUE;
                        REQ_LIN_ID, REQ_LIN_PRICE: state_next = S_LIN;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_LIN: begin
                if (lin_hit || (!lin_issue && !chk_valid_reg)) begin
                    state_next = S_OUT;
                end
            end
            S_BIN_ISSUE: begin
                state_next = (lo_reg < hi_reg) ? S_BIN_CHECK : S_OUT;
            end
            S_BIN_CHECK: begin
                state_next = (rd_rec.id == key_reg) ? S_OUT : S_BIN_ISSUE;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        key_next = key_reg;
        lin_price_next = lin_price_reg;
        lin_addr_next = lin_addr_reg;
        chk_valid_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        res_status_next = res_status_reg;
        res_idx_next = res_idx_reg;
        res_rec_next = res_rec_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    key_next = s_tdata[31:0];
                    lin_price_next = (s_tuser == REQ_LIN_PRICE);
                    lin_addr_next = '0;
                    lo_next = '0;
                    hi_next = count_reg;
                    res_status_next = ST_NOT_FOUND;
                    res_idx_next = '0;
                    res_rec_next = '0;
                    unique case (s_tuser)
                        REQ_CLEAR: begin
                            count_next = '0;
                            res_status_next = ST_OK;
                        end
                        REQ_APPEND: begin
                            if (wr_en) begin
                                count_next = count_reg + CNT_W'(1);
                                res_status_next = ST_OK;
                            end else begin
                                res_status_next = ST_FULL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LIN: begin
                if (lin_issue) begin
                    lin_addr_next = lin_addr_reg + CNT_W'(1);
                end
                chk_valid_next = lin_issue;
                chk_idx_next = lin_addr_reg[IDX_W-1:0];
                if (lin_hit) begin
                    res_status_next = ST_FOUND;
                    res_idx_next = chk_idx_reg;
                    res_rec_next = rd_rec;
                end
            end
            S_BIN_ISSUE: begin
                mid_next = mid_calc[IDX_W-1:0];
            end
            S_BIN_CHECK: begin
                if (rd_rec.id == key_reg) begin
                    res_status_next = ST_FOUND;
                    res_idx_next = mid_reg;
                    res_rec_next = rd_rec;
                end else if ($signed(rd_rec.id) < $signed(key_reg)) begin
                    lo_next = {1'b0, mid_reg} + CNT_W'(1);
                end else begin
                    hi_next = {1'b0, mid_reg};
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lin_price_reg <= lin_price_next;
        lin_addr_reg <= lin_addr_next;
        chk_idx_reg <= chk_idx_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        res_status_reg <= res_status_next;
        res_idx_reg <= res_idx_next;
        res_rec_reg <= res_rec_next;
        if ((state_reg == S_OUT) && out_free) begin
            m_status_reg <= res_status_reg;
            m_idx_reg <= res_idx_reg;
            m_rec_reg <= res_rec_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_status_reg;
    assign m_tdata = {m_rec_reg.rating, m_rec_reg.sold, m_rec_reg.price, m_rec_reg.id,
                      m_idx_reg[HIT_IDX_W-1:0]};

endmodule
